// ----- rtl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and helper functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

endpackage

// ----- rtl/sm3_ram.sv -----
// ----------------------------------------------------------------------------
// sm3_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sm3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sm3_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// Streaming SM3 hash engine: message words in, eight digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one big-endian 32-bit message word per request; in_tlast marks
//           the final word and in_tdata[34:32] gives its valid byte count
//           (0..4).
//   out_* : eight digest words, word 0 first, out_tlast on the eighth;
//           out_tuser is the length overflow flag of that message.
// Timing:
//   A non-final word is written straight into the block buffer RAM. The
//   sixteenth word of a block starts a compression: the block buffer RAM
//   is loaded into the expansion window (one read port, one word per
//   cycle), then 64 rounds run (one round per cycle) and the result is
//   folded into the chaining value.
//   The final word leads to padding and one or two compressions; the eight
//   digest words then go out one per cycle while out_tready is high.
//   in_tready is low while padding, compressing or emitting.
// Reset:
//   Synchronous, active low: chaining value returns to the SM3 initial
//   value, length and word position clear. The same happens after the
//   eighth digest word is taken.
// Stall:
//   The digest word holds on out_tdata until out_tready takes it.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] valid_bytes
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast,  // digest_last
  output logic        out_tuser   // [0] length_overflow
);

  state_t      state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] data_r, data_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic        data_pend_r, data_pend_nxt;
  logic        tail_pend_r, tail_pend_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        final_r, final_nxt;
  logic        padding_r, padding_nxt;
  logic [4:0]  ld_r, ld_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [31:0] tj_r, tj_nxt;
  logic [31:0] cv_r [8];
  logic [31:0] cv_nxt [8];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  logic        in_req;
  logic        out_req;
  logic [2:0]  vb;
  logic [6:0]  add_bits;
  logic [64:0] cnt_sum;
  logic [31:0] tail_word;
  logic [31:0] pad_word;

  logic [31:0] a12, ss, s1, s2, ff, gg, t1, t2, w_new;

  sm3_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ld_r[3:0]),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_req     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_req    = out_tvalid && out_tready;
  assign out_tdata  = cv_r[oidx_r];
  assign out_tlast  = (oidx_r == 3'd7);
  assign out_tuser  = ovf_r;

  // clamp valid byte count and form the bit count increment
  always_comb begin
    vb = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
    add_bits = in_tlast ? {1'b0, vb, 3'b000} : 7'd32;
    cnt_sum = {1'b0, cnt_r} + {58'd0, add_bits};
  end

  // build the padded tail word of a short final word
  always_comb begin
    case (vb)
      3'd0:    tail_word = {PAD_BYTE, 24'd0};
      3'd1:    tail_word = {in_tdata[31:24], PAD_BYTE, 16'd0};
      3'd2:    tail_word = {in_tdata[31:16], PAD_BYTE, 8'd0};
      3'd3:    tail_word = {in_tdata[31:8], PAD_BYTE};
      default: tail_word = {PAD_BYTE, 24'd0};
    endcase
  end

  // select the next padding word
  always_comb begin
    if (data_pend_r) begin
      pad_word = data_r;
    end else if (tail_pend_r) begin
      pad_word = tail_r;
    end else if (len_ok_r && pos_r == 4'd14) begin
      pad_word = cnt_r[63:32];
    end else if (len_ok_r && pos_r == 4'd15) begin
      pad_word = cnt_r[31:0];
    end else begin
      pad_word = 32'd0;
    end
  end

  // one compression round and one expansion step
  always_comb begin
    a12 = rol32(v_r[0], 12);
    ss  = a12 + v_r[4] + tj_r;
    s1  = rol32(ss, 7);
    s2  = s1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    t1 = ff + v_r[3] + s2 + (w_r[0] ^ w_r[4]);
    t2 = gg + v_r[7] + s1 + w_r[0];
    w_new = perm1(w_r[0] ^ w_r[7] ^ rol32(w_r[13], 15)) ^ rol32(w_r[3], 7) ^ w_r[10];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    data_nxt      = data_r;
    tail_nxt      = tail_r;
    data_pend_nxt = data_pend_r;
    tail_pend_nxt = tail_pend_r;
    len_ok_nxt    = len_ok_r;
    final_nxt     = final_r;
    padding_nxt   = padding_r;
    ld_nxt        = ld_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    tj_nxt        = tj_r;
    cv_nxt        = cv_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = in_tdata[31:0];

    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          cnt_nxt = cnt_sum[63:0];
          ovf_nxt = ovf_r | cnt_sum[64];
          if (in_tlast) begin
            data_nxt      = in_tdata[31:0];
            tail_nxt      = tail_word;
            data_pend_nxt = (vb == 3'd4);
            tail_pend_nxt = 1'b1;
            len_ok_nxt    = 1'b0;
            final_nxt     = 1'b0;
            padding_nxt   = 1'b1;
            state_nxt     = ST_PAD;
          end else begin
            ram_we  = 1'b1;
            pos_nxt = pos_r + 4'd1;
            if (pos_r == 4'd15) begin
              ld_nxt    = 5'd0;
              state_nxt = ST_LOAD;
            end
          end
        end
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
        pos_nxt   = pos_r + 4'd1;
        if (data_pend_r) begin
          data_pend_nxt = 1'b0;
        end else if (tail_pend_r) begin
          tail_pend_nxt = 1'b0;
          len_ok_nxt    = (pos_r <= 4'd13);
        end else if (len_ok_r && pos_r == 4'd15) begin
          final_nxt = 1'b1;
        end
        if (pos_r == 4'd15) begin
          ld_nxt    = 5'd0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // shift block words into the expansion window
        ld_nxt = ld_r + 5'd1;
        if (ld_r != 5'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = ram_rdata;
        end
        if (ld_r == 5'd16) begin
          v_nxt     = cv_r;
          tj_nxt    = TJ_LOW;
          rnd_nxt   = 6'd0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        v_nxt[0] = t1;
        v_nxt[1] = v_r[0];
        v_nxt[2] = rol32(v_r[1], 9);
        v_nxt[3] = v_r[2];
        v_nxt[4] = perm0(t2);
        v_nxt[5] = v_r[4];
        v_nxt[6] = rol32(v_r[5], 19);
        v_nxt[7] = v_r[6];
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        tj_nxt  = (rnd_r == 6'd15) ? rol32(TJ_HIGH, 16) : rol32(tj_r, 1);
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          cv_nxt[i] = cv_r[i] ^ v_r[i];
        end
        if (final_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = ST_OUT;
        end else if (padding_r) begin
          len_ok_nxt = len_ok_r | ~tail_pend_r;
          state_nxt  = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_req) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_nxt      = SM3_IV;
            cnt_nxt     = 64'd0;
            ovf_nxt     = 1'b0;
            pos_nxt     = 4'd0;
            padding_nxt = 1'b0;
            final_nxt   = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= 4'd0;
      cnt_r       <= 64'd0;
      ovf_r       <= 1'b0;
      data_pend_r <= 1'b0;
      tail_pend_r <= 1'b0;
      len_ok_r    <= 1'b0;
      final_r     <= 1'b0;
      padding_r   <= 1'b0;
      ld_r        <= 5'd0;
      rnd_r       <= 6'd0;
      oidx_r      <= 3'd0;
      cv_r        <= SM3_IV;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      data_pend_r <= data_pend_nxt;
      tail_pend_r <= tail_pend_nxt;
      len_ok_r    <= len_ok_nxt;
      final_r     <= final_nxt;
      padding_r   <= padding_nxt;
      ld_r        <= ld_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      cv_r        <= cv_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tail_r <= tail_nxt;
    tj_r   <= tj_nxt;
    v_r    <= v_nxt;
    w_r    <= w_nxt;
  end

endmodule
